// File: src/tdsc_pkg.sv
// ----------------------------------------------------------------------------
// Tick-driven seconds clock package
// Beat types, request codes and arithmetic constants shared by the clock
// sequencer and its divider.
// ----------------------------------------------------------------------------
package tdsc_pkg;

  localparam int TICK_W = 32;
  localparam int RATE_W = 8;
  localparam int SEC_W  = 28;   // ticks in one second, at most 255e6
  localparam int US_W   = 20;

  localparam logic [US_W-1:0]   US_PER_SECOND = US_W'(1000000);
  localparam logic [RATE_W-1:0] DEFAULT_RATE  = RATE_W'(16);

  localparam logic [1:0] REQ_SET   = 2'd0;
  localparam logic [1:0] REQ_READ  = 2'd1;
  localparam logic [1:0] REQ_TIMER = 2'd2;

  typedef struct packed {
    logic [1:0]        req_type;
    logic [TICK_W-1:0] tick_value;
    logic [TICK_W-1:0] utc_seconds;
  } in_beat_t;

  typedef struct packed {
    logic [TICK_W-1:0] seconds_now;
    logic              clock_valid;
    logic [TICK_W-1:0] us_left;
  } out_beat_t;

  typedef struct packed {
    logic              start;
    logic [TICK_W-1:0] dividend;
    logic [SEC_W-1:0]  divisor;
  } div_req_t;

  typedef struct packed {
    logic              done;
    logic [TICK_W-1:0] quotient;
    logic [SEC_W-1:0]  remainder;
  } div_res_t;

endpackage

// File: src/tdsc_div.sv
// ----------------------------------------------------------------------------
// Tick-driven seconds clock divider
// Restoring divider, one quotient bit per cycle.
// ----------------------------------------------------------------------------
module tdsc_div
  import tdsc_pkg::*;
(
  input  logic     clk,
  input  logic     rst_n,
  input  div_req_t req,
  output div_res_t res
);

  localparam int CNT_W = $clog2(TICK_W);

  logic              busy_r, busy_nxt;
  logic              done_r, done_nxt;
  logic [CNT_W-1:0]  cnt_r, cnt_nxt;
  logic [SEC_W-1:0]  rem_r, rem_nxt;
  logic [TICK_W-1:0] quo_r, quo_nxt;
  logic [SEC_W-1:0]  dvs_r, dvs_nxt;

  logic [SEC_W:0] trial;
  logic [SEC_W:0] diff;
  logic           ge;

  always_comb begin
    trial = {rem_r, quo_r[TICK_W-1]};
    diff  = trial - {1'b0, dvs_r};
    ge    = (trial >= {1'b0, dvs_r});

    busy_nxt = busy_r;
    done_nxt = 1'b0;
    cnt_nxt  = cnt_r;
    rem_nxt  = rem_r;
    quo_nxt  = quo_r;
    dvs_nxt  = dvs_r;

    if (req.start) begin
      busy_nxt = 1'b1;
      cnt_nxt  = CNT_W'(TICK_W - 1);
      rem_nxt  = '0;
      quo_nxt  = req.dividend;
      dvs_nxt  = req.divisor;
    end else if (busy_r) begin
      // The partial remainder always stays below the divisor.
      rem_nxt = ge ? diff[SEC_W-1:0] : trial[SEC_W-1:0];
      quo_nxt = {quo_r[TICK_W-2:0], ge};
      cnt_nxt = cnt_r - CNT_W'(1);
      if (cnt_r == '0) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
      cnt_r  <= cnt_nxt;
    end
    rem_r <= rem_nxt;
    quo_r <= quo_nxt;
    dvs_r <= dvs_nxt;
  end

  assign res.done      = done_r;
  assign res.quotient  = quo_r;
  assign res.remainder = rem_r;

endmodule

// File: src/tick_driven_seconds_clock_unit.sv
// Requests: one at a time; the next is taken in the cycle after the
// result is registered, even while that result still waits at the output.
// Reset (synchronous, rst_n low) clears the clock state, the rate register
// goes to 16 ticks per microsecond, and no beats are pending.
// ----------------------------------------------------------------------------
// Tick-driven seconds clock
// Keeps a UTC seconds count against a free-running tick counter using one
// shared iterative divider under a small sequencer.
// ----------------------------------------------------------------------------
module tick_driven_seconds_clock_unit
  import tdsc_pkg::*;
(
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_stall,
  input  in_beat_t          in_data,
  output logic              out_valid,
  input  logic              out_stall,
  output out_beat_t         out_data,
  input  logic              cfg_valid,
  output logic              cfg_ready,
  input  logic [RATE_W-1:0] cfg_data
);

  // The sequencer walks one request through these steps. Dispatch applies a
  // set, sends an unused code to done, or decides if a catch-up division is
  // needed; post forms a read answer or starts a timer's microsecond division.
  typedef enum logic [2:0] {
    S_IDLE,
    S_DISPATCH,
    S_CATCH,
    S_POST,
    S_LEFT,
    S_DONE
  } state_t;

  state_t state_r, state_nxt;

  // Configuration: tick rate, written by the user only while idle; unchecked.
  logic [RATE_W-1:0] tpu_r;

  // Latched request.
  logic [1:0]        req_r, req_nxt;
  logic [TICK_W-1:0] now_r, now_nxt;
  logic [TICK_W-1:0] utc_r, utc_nxt;
  logic [RATE_W-1:0] rate_r, rate_nxt;
  logic [SEC_W-1:0]  sec_r, sec_nxt;

  // Clock state.
  logic [TICK_W-1:0] base_r, base_nxt;
  logic [TICK_W-1:0] elapsed_r, elapsed_nxt;
  logic [TICK_W-1:0] nd_r, nd_nxt;
  logic              valid_r, valid_nxt;

  // Result being built and the output register.
  logic [TICK_W-1:0] secs_r, secs_nxt;
  logic [TICK_W-1:0] left_r, left_nxt;
  logic              out_valid_r, out_valid_nxt;
  out_beat_t         out_data_r, out_data_nxt;

  logic [RATE_W-1:0] rate_sel;
  logic [TICK_W-1:0] over;
  logic [TICK_W-1:0] left_raw;
  logic              need_catch;
  div_req_t          div_req;
  div_res_t          div_res;

  tdsc_div u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .req   (div_req),
    .res   (div_res)
  );

  assign cfg_ready = 1'b1;
  assign in_stall  = (state_r != S_IDLE);
  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  // A zero rate register falls back to the default rate.
  assign rate_sel = (tpu_r == '0) ? DEFAULT_RATE : tpu_r;

  // Ticks past the deadline; a set top bit means the deadline is still ahead.
  assign over       = now_r - nd_r;
  assign need_catch = valid_r && !over[TICK_W-1];

  // Rounded-up microseconds: quotient plus one if anything remained.
  assign left_raw = div_res.quotient + TICK_W'(div_res.remainder != '0);

  always_comb begin
    state_nxt     = state_r;
    req_nxt       = req_r;
    now_nxt       = now_r;
    utc_nxt       = utc_r;
    rate_nxt      = rate_r;
    sec_nxt       = sec_r;
    base_nxt      = base_r;
    elapsed_nxt   = elapsed_r;
    nd_nxt        = nd_r;
    valid_nxt     = valid_r;
    secs_nxt      = secs_r;
    left_nxt      = left_r;
    out_valid_nxt = out_valid_r;
    out_data_nxt  = out_data_r;

    div_req.start    = 1'b0;
    div_req.dividend = over;
    div_req.divisor  = sec_r;

    // The output register drains independently of the sequencer.
    if (out_valid_r && !out_stall) begin
      out_valid_nxt = 1'b0;
    end

    case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          req_nxt   = in_data.req_type;
          now_nxt   = in_data.tick_value;
          utc_nxt   = in_data.utc_seconds;
          rate_nxt  = rate_sel;
          sec_nxt   = SEC_W'(US_PER_SECOND) * SEC_W'(rate_sel);
          secs_nxt  = '0;
          left_nxt  = '0;
          state_nxt = S_DISPATCH;
        end
      end

      S_DISPATCH: begin
        case (req_r)
          REQ_SET: begin
            base_nxt    = utc_r;
            elapsed_nxt = '0;
            valid_nxt   = (utc_r != '0);
            nd_nxt      = now_r + TICK_W'(sec_r);
            state_nxt   = S_DONE;
          end
          REQ_READ, REQ_TIMER: begin
            if (need_catch) begin
              div_req.start = 1'b1;
              state_nxt     = S_CATCH;
            end else begin
              state_nxt = S_POST;
            end
          end
          default: begin
            state_nxt = S_DONE;
          end
        endcase
      end

      S_CATCH: begin
        // Seconds passed are quotient plus one. The new deadline is
        // now minus the remainder plus one second, which equals the old
        // deadline advanced by that many whole seconds.
        if (div_res.done) begin
          elapsed_nxt = elapsed_r + div_res.quotient + TICK_W'(1);
          nd_nxt      = now_r - TICK_W'(div_res.remainder) + TICK_W'(sec_r);
          state_nxt   = S_POST;
        end
      end

      S_POST: begin
        if (req_r == REQ_READ) begin
          secs_nxt  = valid_r ? (base_r + elapsed_r) : '0;
          state_nxt = S_DONE;
        end else begin
          div_req.start    = 1'b1;
          div_req.dividend = nd_r - now_r;
          div_req.divisor  = SEC_W'(rate_r);
          state_nxt        = S_LEFT;
        end
      end

      S_LEFT: begin
        if (div_res.done) begin
          left_nxt  = (left_raw == '0) ? TICK_W'(1) : left_raw;
          state_nxt = S_DONE;
        end
      end

      S_DONE: begin
        // Hand over once the output register is free or draining now.
        if (!out_valid_r || !out_stall) begin
          out_valid_nxt            = 1'b1;
          out_data_nxt.seconds_now = secs_r;
          out_data_nxt.clock_valid = valid_r;
          out_data_nxt.us_left     = left_r;
          state_nxt                = S_IDLE;
        end
      end

      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      tpu_r       <= DEFAULT_RATE;
      base_r      <= '0;
      elapsed_r   <= '0;
      nd_r        <= '0;
      valid_r     <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      if (cfg_valid && cfg_ready) begin
        tpu_r <= cfg_data;
      end
      base_r      <= base_nxt;
      elapsed_r   <= elapsed_nxt;
      nd_r        <= nd_nxt;
      valid_r     <= valid_nxt;
      out_valid_r <= out_valid_nxt;
    end
    req_r      <= req_nxt;
    now_r      <= now_nxt;
    utc_r      <= utc_nxt;
    rate_r     <= rate_nxt;
    sec_r      <= sec_nxt;
    secs_r     <= secs_nxt;
    left_r     <= left_nxt;
    out_data_r <= out_data_nxt;
  end

endmodule

// File: sim/tick_driven_seconds_clock_unit_tb.sv
// ----------------------------------------------------------------------------
// Tick-driven seconds clock testbench
// Sends set, read, timer and unused requests into the clock unit. A local
// predictor of the clock state works out each expected result beat, and
// every result beat is checked field by field against the oldest expectation.
// The tick rate register is rewritten between phases while the unit is idle,
// and both channels stall and idle at random.
// ----------------------------------------------------------------------------
module tick_driven_seconds_clock_unit_tb;
  import tdsc_pkg::*;

  // The request selector has one code that the package leaves unnamed.
  localparam logic [1:0] REQ_UNUSED = 2'd3;

  // Run limits, in clock cycles. The slowest item is a timer request with a
  // catch-up division, plus a random gap before it. Roughly 600 items, one long
  // receiver hold-off and the phase drains stay far below this limit.
  localparam int RUN_LIMIT    = 400000;
  localparam int SETTLE_SPAN  = 80;
  localparam int HOLD_SPAN    = 300;

  logic      clk;
  logic      rst_n;
  logic      in_valid;
  logic      in_stall;
  in_beat_t  in_data;
  logic      out_valid;
  logic      out_stall;
  out_beat_t out_data;
  logic              cfg_valid;
  logic              cfg_ready;
  logic [RATE_W-1:0] cfg_data;

  // Shadow copy of the clock state, kept in step with every accepted beat.
  logic [RATE_W-1:0] rate_reg    = DEFAULT_RATE;
  logic [31:0]       base_sec    = '0;
  logic [31:0]       elapsed_sec = '0;
  logic [31:0]       due_tick    = '0;
  logic              clock_ok    = 1'b0;

  // Result beats still owed by the unit, oldest first.
  out_beat_t expected_beats[$];

  int          errors       = 0;
  bit          idle_on      = 1'b1;  // random gaps on both channels
  bit          hold_request = 1'b0;  // asks the receiver for a long hold-off
  int          hold_left    = 0;
  int          stall_left   = 0;
  logic [31:0] last_tick    = '0;    // tick of the most recent request
  int          cycle_count;

  tick_driven_seconds_clock_unit dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_data  (cfg_data)
  );

  initial clk = 1'b0;
  always #6 clk = ~clk;

  // --------------------------------------------------------------------------
  // Clock predictor
  // --------------------------------------------------------------------------

  // A rate of zero in the register stands for the default rate.
  function automatic logic [RATE_W-1:0] effective_rate();
    return (rate_reg == '0) ? DEFAULT_RATE : rate_reg;
  endfunction

  // Ticks in one second; at most 255e6, so it always fits in 32 bits.
  function automatic logic [31:0] second_ticks();
    logic [31:0] us_sec;
    logic [31:0] rate32;
    us_sec = 32'(US_PER_SECOND);
    rate32 = 32'(effective_rate());
    return us_sec * rate32;
  endfunction

  // Advance the elapsed count by every second whose deadline has passed.
  // The tick compare is done with wrap: an overshoot with the top bit set
  // means the deadline still lies ahead.
  function automatic void catch_up_seconds(input logic [31:0] tick);
    logic [31:0] over;
    logic [31:0] steps;
    if (!clock_ok) return;
    over = tick - due_tick;
    if (over[31]) return;
    steps = over / second_ticks() + 32'd1;
    elapsed_sec += steps;
    due_tick    += steps * second_ticks();
  endfunction

  // Microseconds to the deadline, rounded up over a 64-bit sum so that the
  // rounding term cannot overflow, and never less than one.
  function automatic logic [31:0] us_until_deadline(input logic [31:0] tick);
    logic [31:0] gap_ticks;
    logic [63:0] rate64;
    logic [63:0] us;
    gap_ticks = due_tick - tick;
    rate64    = 64'(effective_rate());
    us        = ({32'd0, gap_ticks} + rate64 - 64'd1) / rate64;
    return (us[31:0] == '0) ? 32'd1 : us[31:0];
  endfunction

  function automatic out_beat_t predict_clock_beat(input in_beat_t beat);
    out_beat_t res;
    res = '0;
    case (beat.req_type)
      REQ_SET: begin
        base_sec    = beat.utc_seconds;
        elapsed_sec = '0;
        clock_ok    = (beat.utc_seconds != '0);
        due_tick    = beat.tick_value + second_ticks();
      end
      REQ_READ: begin
        // A read on an invalid clock neither catches up nor reports time.
        if (clock_ok) begin
          catch_up_seconds(beat.tick_value);
          res.seconds_now = base_sec + elapsed_sec;
        end
      end
      REQ_TIMER: begin
        catch_up_seconds(beat.tick_value);
        res.us_left = us_until_deadline(beat.tick_value);
      end
      default: begin
        // The unused selector leaves the state alone.
      end
    endcase
    res.clock_valid = clock_ok;
    return res;
  endfunction

  // --------------------------------------------------------------------------
  // Result checker: every accepted result beat is matched against the oldest
  // expectation. Values are sampled at the rising edge, before any of the
  // nonblocking updates of that edge take effect.
  // --------------------------------------------------------------------------
  always @(posedge clk) begin
    out_beat_t want;
    if (rst_n && out_valid && !out_stall) begin
      if (expected_beats.size() == 0) begin
        $display("%0t unexpected result beat %h", $time, out_data);
        errors++;
      end else begin
        want = expected_beats.pop_front();
        if (out_data.seconds_now !== want.seconds_now) begin
          $display("%0t seconds_now expected %h actual %h",
                   $time, want.seconds_now, out_data.seconds_now);
          errors++;
        end
        if (out_data.clock_valid !== want.clock_valid) begin
          $display("%0t clock_valid expected %b actual %b",
                   $time, want.clock_valid, out_data.clock_valid);
          errors++;
        end
        if (out_data.us_left !== want.us_left) begin
          $display("%0t us_left expected %h actual %h",
                   $time, want.us_left, out_data.us_left);
          errors++;
        end
      end
    end
  end

  // --------------------------------------------------------------------------
  // Result receiver. After each accepted beat it draws how many cycles to
  // stall before the next one. On request it holds off for a long stretch,
  // counted here, so that the unit backs up and stalls its input.
  // --------------------------------------------------------------------------
  always @(posedge clk) begin
    if (!rst_n) begin
      out_stall <= 1'b0;
      stall_left = 0;
    end else begin
      if (hold_request) begin
        hold_left    = HOLD_SPAN;
        hold_request = 1'b0;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_stall <= 1'b1;
      end else begin
        if (out_valid && !out_stall) begin
          stall_left = idle_on ? $urandom_range(0, 4) : 0;
        end else if (stall_left > 0) begin
          stall_left--;
        end
        out_stall <= (stall_left > 0);
      end
    end
  end

  // Timeout watchdog.
  initial begin
    cycle_count = 0;
    while (cycle_count < RUN_LIMIT) begin
      @(posedge clk);
      cycle_count++;
    end
    $display("timeout after %0d cycles", cycle_count);
    $display("RESULT: ERROR");
    $finish;
  end

  // --------------------------------------------------------------------------
  // Shared driving tasks
  // --------------------------------------------------------------------------

  // Offers one request beat and returns at the edge where it is accepted.
  // in_valid stays high afterwards so that back-to-back beats need no gap;
  // the next call lowers it only when it draws a gap.
  task automatic send_request(input logic [1:0] req, input logic [31:0] tick,
                              input logic [31:0] utc);
    in_beat_t beat;
    int       gap;
    beat.req_type    = req;
    beat.tick_value  = tick;
    beat.utc_seconds = utc;
    gap = idle_on ? $urandom_range(0, 4) : 0;
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= beat;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    expected_beats.push_back(predict_clock_beat(beat));
    last_tick = tick;
  endtask

  // Waits until every owed result has come back; each request yields exactly
  // one result, so the unit is idle by then.
  task automatic drain_results();
    in_valid <= 1'b0;
    while (expected_beats.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic write_rate(input logic [RATE_W-1:0] value);
    drain_results();
    cfg_valid <= 1'b1;
    cfg_data  <= value;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    cfg_valid <= 1'b0;
    rate_reg = value;
    repeat (2) @(posedge clk);
  endtask

  // Picks the tick of the next request in a sequence: mostly forward by up
  // to a few seconds, sometimes right at the deadline, sometimes behind the
  // last tick, and now and then anywhere.
  function automatic logic [31:0] next_tick();
    case ($urandom_range(0, 9))
      0:          return last_tick;
      1, 2, 3, 4: return last_tick + $urandom_range(0, second_ticks());
      5, 6:       return last_tick + $urandom_range(0, 4 * second_ticks());
      7:          return due_tick - 32'd1 + $urandom_range(0, 2);
      8:          return last_tick - $urandom_range(0, second_ticks());
      default:    return $urandom();
    endcase
  endfunction

  // --------------------------------------------------------------------------
  // Tests
  // --------------------------------------------------------------------------

  // Timer, read and unused requests straight out of reset. The timer counts
  // to the reset deadline at tick zero through the wrapped difference.
  task automatic test_before_set();
    send_request(REQ_TIMER, 32'd0, 32'd0);
    send_request(REQ_TIMER, 32'd1, 32'hFFFF_FFFF);
    send_request(REQ_READ, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
    send_request(REQ_UNUSED, 32'h1234_5678, 32'hDEAD_BEEF);
  endtask

  // Setting zero leaves the clock invalid; then a valid clock is read just
  // before, exactly at and well past its deadlines, and once with a tick that
  // lies behind the deadline so that no catch-up happens.
  task automatic test_set_and_read();
    logic [31:0] st;
    st = second_ticks();
    send_request(REQ_SET, 32'h100, 32'd0);
    send_request(REQ_READ, 32'h100 + 3 * st, 32'd0);
    send_request(REQ_SET, 32'h100, 32'd1000);
    send_request(REQ_READ, 32'h100 + st - 32'd1, 32'd0);
    send_request(REQ_READ, 32'h100 + st, 32'd0);
    send_request(REQ_TIMER, 32'h100 + st + 32'd5, 32'd0);
    send_request(REQ_READ, 32'h100 + 10 * st + 32'd7, 32'd0);
    send_request(REQ_READ, 32'h100, 32'd0);
  endtask

  // A deadline that lands on tick zero is an ordinary deadline, and the
  // seconds count wraps past the top of its range.
  task automatic test_wrap_and_zero_deadline();
    logic [31:0] st;
    st = second_ticks();
    send_request(REQ_SET, 32'd0 - st, 32'hFFFF_FFFF);
    send_request(REQ_TIMER, 32'hFFFF_FFFF, 32'd0);
    send_request(REQ_READ, 32'd0, 32'd0);
    send_request(REQ_READ, 32'h7FFF_FFFF, 32'd0);
    send_request(REQ_TIMER, 32'hFFFF_FFF0, 32'd0);
  endtask

  // Highest and lowest rates, and a zero rate that falls back to the default.
  task automatic test_rate_extremes();
    write_rate(8'd255);
    send_request(REQ_SET, 32'hFFFF_FFFF, 32'd1);
    send_request(REQ_TIMER, 32'hFFFF_FFFF, 32'd0);
    write_rate(8'd1);
    send_request(REQ_SET, 32'd0, 32'd5);
    send_request(REQ_TIMER, 32'd3, 32'd0);
    write_rate(8'd0);
    send_request(REQ_SET, 32'd0, 32'd7);
    send_request(REQ_TIMER, 32'd1, 32'd0);
    send_request(REQ_READ, 32'hFFFF_FFFF, 32'd0);
  endtask

  // Mostly well-formed sequences: a set, then reads, timer requests and rare
  // sets at mostly advancing ticks. The rest is random noise on all fields.
  task automatic test_random_traffic(input int count);
    int         sent;
    int         steps;
    int         pick;
    logic [1:0] req;
    sent = 0;
    while (sent < count) begin
      if ($urandom_range(0, 99) < 85) begin
        send_request(REQ_SET, $urandom(),
                     ($urandom_range(0, 15) == 0) ? 32'd0 : $urandom());
        steps = $urandom_range(1, 8);
        for (int i = 0; i < steps; i++) begin
          pick = $urandom_range(0, 9);
          req  = (pick < 5) ? REQ_READ : (pick < 9) ? REQ_TIMER : REQ_SET;
          send_request(req, next_tick(), $urandom());
        end
        sent += steps + 1;
      end else begin
        send_request(2'($urandom_range(0, 3)), $urandom(), $urandom());
        sent++;
      end
    end
  endtask

  // The receiver holds off while requests keep coming, so that the unit
  // fills up and stalls its input.
  task automatic test_backpressure();
    drain_results();
    idle_on      = 1'b0;
    hold_request = 1'b1;
    send_request(REQ_SET, $urandom(), $urandom());
    for (int i = 0; i < 11; i++) begin
      send_request(($urandom_range(0, 1) == 0) ? REQ_READ : REQ_TIMER,
                   next_tick(), $urandom());
    end
    idle_on = 1'b1;
    drain_results();
  endtask

  // --------------------------------------------------------------------------
  // Main sequence
  // --------------------------------------------------------------------------
  initial begin
    rst_n     = 1'b0;
    in_valid  = 1'b0;
    in_data   = '0;
    cfg_valid = 1'b0;
    cfg_data  = '0;
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed checks, starting from the reset rate.
    test_before_set();
    test_set_and_read();
    test_wrap_and_zero_deadline();
    test_rate_extremes();

    // Random phases across several rates, one of them without any idling.
    write_rate(DEFAULT_RATE);
    test_random_traffic(110);
    write_rate(RATE_W'($urandom_range(2, 254)));
    idle_on = 1'b0;
    test_random_traffic(110);
    idle_on = 1'b1;
    write_rate(8'd1);
    test_random_traffic(110);
    write_rate(8'd255);
    test_random_traffic(110);
    write_rate(8'd0);
    test_random_traffic(60);
    test_backpressure();

    drain_results();
    repeat (SETTLE_SPAN) @(posedge clk);
    if (errors == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule
